// ===== design/des_pkg.sv =====
// Package for the DES block cipher: permutation tables, S-boxes and
// helper functions for the key schedule and the Feistel rounds.
// No dependencies; imported by all DES modules.
`default_nettype none

package des_pkg;

	localparam int NumRounds  = 16;
	localparam int BlockWidth = 64;
	localparam int HalfWidth  = 32;
	localparam int KeyWidth   = 64;
	localparam int SubkeyWidth = 48;
	localparam int CdWidth    = 28;

	localparam logic [3:0] KeyAddr = 4'h0;

	localparam logic [6:0] IpTab [64] = '{
		7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
		7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
		7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
		7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
		7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
		7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
		7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
	};

	localparam logic [6:0] FpTab [64] = '{
		7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
		7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
		7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
		7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
		7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
		7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
		7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
		7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
	};

	localparam logic [5:0] ETab [48] = '{
		6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
		6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
		6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
		6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
		6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
		6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
		6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
	};

	localparam logic [5:0] PTab [32] = '{
		6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
		6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
		6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
		6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
	};

	localparam logic [6:0] Pc1Tab [56] = '{
		7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
		7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
		7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
		7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
		7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
		7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
		7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
		7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
	};

	localparam logic [5:0] Pc2Tab [48] = '{
		6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
		6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
		6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
		6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
		6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
		6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
		6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
		6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
	};

	// total left rotation of C and D after each round
	localparam logic [4:0] RotSumTab [16] = '{
		5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
		5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
	};

	localparam logic [3:0] SboxTab [8][64] = '{
		'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
		  4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
		  4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
		  4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
		'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
		  4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
		  4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
		  4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
		'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
		  4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
		  4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
		  4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
		'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
		  4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
		  4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
		  4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
		'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
		  4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
		  4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
		  4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
		'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
		  4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
		  4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
		  4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
		'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
		  4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
		  4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
		  4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
		'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
		  4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
		  4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
		  4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
	};

	// table entries count bit positions from 1 at the MSB
	function automatic logic [63:0] des_ip(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63 - i] = v[64 - int'(IpTab[i])];
		return r;
	endfunction

	function automatic logic [63:0] des_fp(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63 - i] = v[64 - int'(FpTab[i])];
		return r;
	endfunction

	function automatic logic [47:0] des_expand(input logic [31:0] v);
		logic [47:0] r;
		for (int i = 0; i < 48; i++) r[47 - i] = v[32 - int'(ETab[i])];
		return r;
	endfunction

	function automatic logic [31:0] des_pbox(input logic [31:0] v);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) r[31 - i] = v[32 - int'(PTab[i])];
		return r;
	endfunction

	function automatic logic [55:0] des_pc1(input logic [63:0] v);
		logic [55:0] r;
		for (int i = 0; i < 56; i++) r[55 - i] = v[64 - int'(Pc1Tab[i])];
		return r;
	endfunction

	function automatic logic [47:0] des_pc2(input logic [55:0] v);
		logic [47:0] r;
		for (int i = 0; i < 48; i++) r[47 - i] = v[56 - int'(Pc2Tab[i])];
		return r;
	endfunction

	function automatic logic [27:0] des_rotl28(input logic [27:0] v, input int n);
		logic [55:0] vv;
		vv = {v, v};
		return vv[55 - n -: 28];
	endfunction

	// six input bits b5..b0: row {b5,b0}, column b4..b1
	function automatic logic [31:0] des_sboxes(input logic [47:0] x);
		logic [31:0] s;
		logic [5:0] six;
		for (int i = 0; i < 8; i++) begin
			six = x[47 - 6 * i -: 6];
			s[31 - 4 * i -: 4] = SboxTab[i][{six[5], six[0], six[4:1]}];
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== design/des_key_sched.sv =====
// DES key schedule: PC-1, cumulative rotations of C and D, and PC-2 for
// all sixteen round subkeys. Depends on des_pkg.
`default_nettype none

module des_key_sched (
	input  wire logic [des_pkg::KeyWidth-1:0]    key,
	output logic      [des_pkg::SubkeyWidth-1:0] subkey [des_pkg::NumRounds]
);
	import des_pkg::*;

	logic [2*CdWidth-1:0] cd;
	logic [CdWidth-1:0]   c0;
	logic [CdWidth-1:0]   d0;

	assign cd = des_pc1(key);
	assign c0 = cd[2*CdWidth-1:CdWidth];
	assign d0 = cd[CdWidth-1:0];

	for (genvar g = 0; g < NumRounds; g++) begin : g_round
		assign subkey[g] = des_pc2({des_rotl28(c0, int'(RotSumTab[g])),
			des_rotl28(d0, int'(RotSumTab[g]))});
	end

endmodule

`default_nettype wire

// ===== design/des_round.sv =====
// One DES Feistel round: expansion, subkey XOR, S-boxes and P permutation.
// Depends on des_pkg.
`default_nettype none

module des_round (
	input  wire logic [des_pkg::HalfWidth-1:0]   l_in,
	input  wire logic [des_pkg::HalfWidth-1:0]   r_in,
	input  wire logic [des_pkg::SubkeyWidth-1:0] subkey,
	output logic      [des_pkg::HalfWidth-1:0]   l_out,
	output logic      [des_pkg::HalfWidth-1:0]   r_out
);
	import des_pkg::*;

	logic [47:0] x;

	assign x     = des_expand(r_in) ^ subkey;
	assign l_out = r_in;
	assign r_out = l_in ^ des_pbox(des_sboxes(x));

endmodule

`default_nettype wire

// ===== design/des_block_cipher.sv =====
// Single DES engine: one 64-bit block per item, encrypt or decrypt.
// Depends on des_pkg, des_key_sched and des_round.
//
// Takes one item per clock unless out_stall holds the result register full.
// Each item is held in the input register, passes IP, all sixteen rounds and
// the final permutation in one combinational path (which sets the clock
// period), and lands in the result register. The key is written over the
// APB-style port at byte address 0 (64-bit data); the user must write it
// only while no item is in flight (not enforced); subkeys follow the key.
`default_nettype none

module des_block_cipher (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [3:0]                     paddr,
	input  wire logic [63:0]                    pwdata,
	output logic      [63:0]                    prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           command,
	input  wire logic [des_pkg::BlockWidth-1:0] block_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [des_pkg::BlockWidth-1:0] block_out
);
	import des_pkg::*;

	logic [KeyWidth-1:0]    key_q;
	logic                   valid_s1;
	logic                   command_s1;
	logic [BlockWidth-1:0]  block_s1;
	logic                   valid_s2;
	logic [BlockWidth-1:0]  block_s2;
	logic                   adv_out;
	logic                   load_s1;
	logic [SubkeyWidth-1:0] subkey [NumRounds];
	logic [HalfWidth-1:0]   l_w [NumRounds + 1];
	logic [HalfWidth-1:0]   r_w [NumRounds + 1];
	logic [BlockWidth-1:0]  result;

	assign pready = 1'b1;
	assign prdata = (paddr == KeyAddr) ? key_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (psel && penable && pwrite && paddr == KeyAddr) begin
			key_q <= pwdata;
		end
	end

	des_key_sched u_key_sched (
		.key    (key_q),
		.subkey (subkey)
	);

	assign {l_w[0], r_w[0]} = des_ip(block_s1);

	for (genvar g = 0; g < NumRounds; g++) begin : g_round
		des_round u_round (
			.l_in   (l_w[g]),
			.r_in   (r_w[g]),
			.subkey (command_s1 ? subkey[NumRounds - 1 - g] : subkey[g]),
			.l_out  (l_w[g + 1]),
			.r_out  (r_w[g + 1])
		);
	end

	assign result = des_fp({r_w[NumRounds], l_w[NumRounds]});

	assign adv_out  = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || adv_out;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) valid_s1 <= in_valid;
			if (adv_out) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			command_s1 <= command;
			block_s1   <= block_in;
		end
		if (adv_out && valid_s1) begin
			block_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign block_out = block_s2;

endmodule

`default_nettype wire
